// ===== sv/tfec_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-floor elevator controller package
// Item types for the sensor snapshot channel and the actuator result channel.
// ----------------------------------------------------------------------------
`default_nettype none

package tfec_pkg;

  // One bit per floor, bit 0 is floor 1
  localparam int unsigned FLOORS = 3;
  localparam int unsigned MODE_W = 4;

  typedef logic [FLOORS-1:0] floor_vec_t;

  // Sensor snapshot item
  typedef struct packed {
    floor_vec_t call_buttons;
    floor_vec_t door_closed_sensors;
    floor_vec_t door_open_sensors;
    floor_vec_t at_floor_sensors;
  } tfec_in_t;

  // Actuator result item
  typedef struct packed {
    floor_vec_t        request_lamps;
    floor_vec_t        door_open_drive;
    floor_vec_t        door_close_drive;
    logic              motor_up;
    logic              motor_down;
    logic [MODE_W-1:0] current_mode;
  } tfec_out_t;

endpackage

`default_nettype wire

// ===== sv/tfec_fsm.sv =====
// ----------------------------------------------------------------------------
// Elevator state machine
// Holds the mode, pending requests, heading flag and actuator commands, and
// computes the next values from one registered snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module tfec_fsm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire tfec_pkg::tfec_in_t snap,
  output tfec_pkg::tfec_out_t     res
);
  import tfec_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    M_AT1    = 4'd0,
    M_AT2    = 4'd1,
    M_AT3    = 4'd2,
    M_OPEN1  = 4'd3,
    M_OPEN2  = 4'd4,
    M_OPEN3  = 4'd5,
    M_CLOSE1 = 4'd6,
    M_CLOSE2 = 4'd7,
    M_CLOSE3 = 4'd8,
    M_UP     = 4'd9,
    M_DOWN   = 4'd10
  } mode_t;

  mode_t      mode_r, mode_nxt;
  floor_vec_t pend_r, pend_nxt;
  floor_vec_t dopen_r, dopen_nxt;
  floor_vec_t dclose_r, dclose_nxt;
  logic       head_up_r, head_up_nxt;
  logic       drv_up_r, drv_up_nxt;
  logic       drv_dn_r, drv_dn_nxt;
  logic [1:0] f;
  floor_vec_t fbit;

  // Next-state logic for one snapshot
  always_comb begin
    pend_nxt    = pend_r | snap.call_buttons;
    mode_nxt    = mode_r;
    dopen_nxt   = dopen_r;
    dclose_nxt  = dclose_r;
    head_up_nxt = head_up_r;
    drv_up_nxt  = drv_up_r;
    drv_dn_nxt  = drv_dn_r;
    f           = 2'd0;
    fbit        = '0;
    case (mode_r)
      M_AT1, M_AT2, M_AT3: begin
        f    = mode_r[1:0];
        fbit = FLOORS'(1) << f;
        if ((pend_nxt & fbit) != '0) begin
          mode_nxt = mode_t'(MODE_W'(M_OPEN1) + MODE_W'(f));
        end else if ((snap.door_closed_sensors & fbit) != '0) begin
          // Depart: floor 1 goes up, floor 3 goes down, floor 2 follows heading
          dclose_nxt = dclose_r & ~fbit;
          if (mode_r == M_AT1) begin
            drv_up_nxt  = 1'b1;
            head_up_nxt = 1'b1;
            mode_nxt    = M_UP;
          end else if (mode_r == M_AT3) begin
            drv_dn_nxt  = 1'b1;
            head_up_nxt = 1'b0;
            mode_nxt    = M_DOWN;
          end else if (head_up_r) begin
            drv_up_nxt = 1'b1;
            mode_nxt   = M_UP;
          end else begin
            drv_dn_nxt = 1'b1;
            mode_nxt   = M_DOWN;
          end
        end
      end
      M_OPEN1, M_OPEN2, M_OPEN3: begin
        f    = 2'(MODE_W'(mode_r) - MODE_W'(M_OPEN1));
        fbit = FLOORS'(1) << f;
        if ((snap.door_closed_sensors & fbit) != '0) begin
          dopen_nxt = dopen_r | fbit;
          mode_nxt  = mode_t'(MODE_W'(M_CLOSE1) + MODE_W'(f));
        end
      end
      M_CLOSE1, M_CLOSE2, M_CLOSE3: begin
        f         = 2'(MODE_W'(mode_r) - MODE_W'(M_CLOSE1));
        fbit      = FLOORS'(1) << f;
        dopen_nxt = dopen_r & ~fbit;
        // Closing done: drop the request of this floor
        if ((snap.door_open_sensors & fbit) != '0) begin
          dclose_nxt = dclose_r | fbit;
          pend_nxt   = pend_nxt & ~fbit;
          mode_nxt   = mode_t'(MODE_W'(M_AT1) + MODE_W'(f));
        end
      end
      M_UP: begin
        // Floor 2 wins over floor 3
        if (snap.at_floor_sensors[1]) begin
          drv_up_nxt = 1'b0;
          mode_nxt   = M_AT2;
        end else if (snap.at_floor_sensors[2]) begin
          drv_up_nxt = 1'b0;
          mode_nxt   = M_AT3;
        end
      end
      M_DOWN: begin
        // Floor 2 wins over floor 1
        if (snap.at_floor_sensors[1]) begin
          drv_dn_nxt = 1'b0;
          mode_nxt   = M_AT2;
        end else if (snap.at_floor_sensors[0]) begin
          drv_dn_nxt = 1'b0;
          mode_nxt   = M_AT1;
        end
      end
      default: begin
        // Unused codes hold and only latch requests
        mode_nxt = mode_r;
      end
    endcase
  end

  // Hold state, advance once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_AT1;
      pend_r    <= '0;
      head_up_r <= 1'b1;
      dopen_r   <= '0;
      dclose_r  <= '0;
      drv_up_r  <= 1'b0;
      drv_dn_r  <= 1'b0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      pend_r    <= pend_nxt;
      head_up_r <= head_up_nxt;
      dopen_r   <= dopen_nxt;
      dclose_r  <= dclose_nxt;
      drv_up_r  <= drv_up_nxt;
      drv_dn_r  <= drv_dn_nxt;
    end
  end

  // Result item is the state after this snapshot
  always_comb begin
    res.request_lamps    = pend_nxt;
    res.door_open_drive  = dopen_nxt;
    res.door_close_drive = dclose_nxt;
    res.motor_up         = drv_up_nxt;
    res.motor_down       = drv_dn_nxt;
    res.current_mode     = MODE_W'(mode_nxt);
  end

endmodule

`default_nettype wire

// ===== sv/three_floor_elevator_controller.sv =====
// ----------------------------------------------------------------------------
// Three-floor elevator controller
// Takes sensor snapshots and returns the held actuator commands, one result
// item per snapshot item.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------
//   in_     | in  | in_valid / in_ready    | in_item  (tfec_in_t)
//   out_    | out | out_valid / out_ready  | out_item (tfec_out_t)
//
// One item per clock while the output is not stalled: snapshot register,
// next-state logic, result register. out_valid rises once the accepted snapshot
// has stepped through the next-state logic into the result register.
// Synchronous active-low reset puts the cabin at floor 1, heading up, all
// commands and requests cleared.
// A stalled output holds its item; the snapshot register keeps accepting as
// long as the result register can take its item in the same cycle.
`default_nettype none

module three_floor_elevator_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tfec_pkg::tfec_in_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tfec_pkg::tfec_out_t     out_item
);
  import tfec_pkg::*;

  logic      snap_valid_r;
  tfec_in_t  snap_r;
  logic      res_valid_r;
  tfec_out_t res_r;
  tfec_out_t res_nxt;
  logic      step_en;

  // Advance the snapshot when the result register is free or draining
  assign step_en  = snap_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !snap_valid_r || step_en;

  tfec_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .snap    (snap_r),
    .res     (res_nxt)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        snap_valid_r <= in_valid;
      end
      if (step_en) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      snap_r <= in_item;
    end
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_item  = res_r;

endmodule

`default_nettype wire
